// ----- rtl/ccci_pkg.sv -----
`timescale 1ns / 1ps
// ccci_pkg: types, constants and widths shared by the cubic curve color interpolator.
// Has no dependencies. Every other file in rtl/ except ccci_ram refers to it by scoped names.
package ccci_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int NUM_TAPS    = 4;
    localparam int TAP_W       = 2;
    localparam int NUM_CH      = 3;
    localparam int CHAN_W      = 16;
    localparam int IDX_W       = 8;
    localparam int IDX_EXT_W   = IDX_W + 2;
    localparam int U_W         = 13;
    localparam int NUM_STAGES  = 8;

    localparam int BANK_DEPTH = TABLE_DEPTH / NUM_TAPS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam logic [IDX_EXT_W-1:0] DEPTH_EXT  = IDX_EXT_W'(TABLE_DEPTH);
    localparam logic [IDX_EXT_W-1:0] LAST_LIN   = IDX_EXT_W'(2);
    localparam logic [IDX_EXT_W-1:0] LAST_CUBIC = IDX_EXT_W'(3);

    localparam logic [U_W-1:0] ONE_Q12 = U_W'(4096);

    // Weight datapath: squares fit in 25 bits, cubes in 37, weights in 40 signed.
    localparam int SQ_W      = 2 * U_W - 1;
    localparam int CUBE_W    = 3 * U_W - 2;
    localparam int WGT_W     = 40;
    localparam int CALC_W    = 42;
    localparam int LIN_SHIFT = 25;

    localparam logic signed [CALC_W-1:0] TWO_Q36 = CALC_W'(64'h20_0000_0000);

    // Accumulation and rounding: everything is scaled to a divisor of 2^37,
    // the B-spline additionally divides by three afterwards.
    localparam int PROD_W    = WGT_W + CHAN_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int RND_SHIFT = 37;
    localparam int Y_W       = ACC_W - RND_SHIFT;

    localparam logic signed [ACC_W-1:0] BIAS_HALF = ACC_W'(64'h10_0000_0000);
    localparam logic signed [ACC_W-1:0] BIAS_BSPL = ACC_W'(64'h30_0000_0000);

    localparam int DIV3_IN_W   = 19;
    localparam int DIV3_MUL_W  = 20;
    localparam int DIV3_PROD_W = DIV3_IN_W + DIV3_MUL_W;
    localparam int DIV3_SHIFT  = 21;
    localparam int Q_W         = DIV3_PROD_W - DIV3_SHIFT;

    localparam logic [Y_W-1:0]        Y_OFF    = Y_W'(393216);
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = DIV3_MUL_W'(699051);
    localparam logic signed [Y_W-1:0] Q_OFF    = Y_W'(131072);

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_LINEAR  = 2'd1,
        CMD_BSPLINE = 2'd2,
        CMD_CATMULL = 2'd3
    } cmd_t;

    typedef logic signed [CHAN_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0]       pix_t;
    typedef pix_t [NUM_TAPS-1:0]      tap_pix_t;
    typedef chan_t [NUM_TAPS-1:0]     tap_chan_t;
    typedef logic signed [WGT_W-1:0]  wgt_t;
    typedef wgt_t [NUM_TAPS-1:0]      wgt_vec_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [IDX_W-1:0]   index;
        logic [U_W-1:0]     param_u;
        logic signed [15:0] write_red;
        logic signed [15:0] write_green;
        logic signed [15:0] write_blue;
    } request_t;

    typedef struct packed {
        logic signed [15:0] out_red;
        logic signed [15:0] out_green;
        logic signed [15:0] out_blue;
        logic               range_error;
    } result_t;

    typedef struct packed {
        logic valid;
        logic err;
        cmd_t cmd;
    } stage_ctl_t;

endpackage

// ----- rtl/ccci_ram.sv -----
`timescale 1ns / 1ps
// ccci_ram: generic single-write, single-read memory with registered read data.
// Stand-alone; used for each bank of the control color table.
module ccci_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ccci_weights.sv -----
`timescale 1ns / 1ps
// ccci_weights: four-stage pipeline that turns the clamped parameter into the four
// basis weights (Q.36, scaled to a common 2^37 divisor). Depends on ccci_pkg.
module ccci_weights (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [ccci_pkg::U_W-1:0]      t,
    input  logic [ccci_pkg::U_W-1:0]      s,
    input  ccci_pkg::cmd_t                mode,
    output ccci_pkg::wgt_vec_t            wgt
);

    logic [ccci_pkg::U_W-1:0]              t1_reg, s1_reg, t2_reg, s2_reg, t3_reg, s3_reg;
    logic [2*ccci_pkg::U_W-1:0]            tt_full, ss_full;
    logic [ccci_pkg::SQ_W-1:0]             tt2_reg, ss2_reg, tt3_reg, ss3_reg;
    logic [ccci_pkg::SQ_W+ccci_pkg::U_W-1:0] ttt_full, sss_full, tts_full, tss_full;
    logic [ccci_pkg::CUBE_W-1:0]           ttt_reg, sss_reg, tts_reg, tss_reg;
    logic signed [ccci_pkg::CALC_W-1:0]    te, se, tte, sse, ttte, ssse, ttse, tsse;
    logic signed [ccci_pkg::CALC_W-1:0]    w_calc [ccci_pkg::NUM_TAPS];
    ccci_pkg::wgt_vec_t                    wgt_reg;

    always_comb
    begin
        tt_full  = t1_reg * t1_reg;
        ss_full  = s1_reg * s1_reg;
        ttt_full = tt2_reg * t2_reg;
        sss_full = ss2_reg * s2_reg;
        tts_full = tt2_reg * s2_reg;
        tss_full = ss2_reg * t2_reg;
    end

    always_comb
    begin
        te   = $signed({{(ccci_pkg::CALC_W-ccci_pkg::U_W){1'b0}}, t3_reg});
        se   = $signed({{(ccci_pkg::CALC_W-ccci_pkg::U_W){1'b0}}, s3_reg});
        tte  = $signed({{(ccci_pkg::CALC_W-ccci_pkg::SQ_W){1'b0}}, tt3_reg});
        sse  = $signed({{(ccci_pkg::CALC_W-ccci_pkg::SQ_W){1'b0}}, ss3_reg});
        ttte = $signed({{(ccci_pkg::CALC_W-ccci_pkg::CUBE_W){1'b0}}, ttt_reg});
        ssse = $signed({{(ccci_pkg::CALC_W-ccci_pkg::CUBE_W){1'b0}}, sss_reg});
        ttse = $signed({{(ccci_pkg::CALC_W-ccci_pkg::CUBE_W){1'b0}}, tts_reg});
        tsse = $signed({{(ccci_pkg::CALC_W-ccci_pkg::CUBE_W){1'b0}}, tss_reg});

        unique case (mode)
            ccci_pkg::CMD_LINEAR:
            begin
                // Linear weights are lifted by 2^25 so they share the 2^37 divisor.
                w_calc[0] = '0;
                w_calc[1] = se <<< ccci_pkg::LIN_SHIFT;
                w_calc[2] = te <<< ccci_pkg::LIN_SHIFT;
                w_calc[3] = '0;
            end
            ccci_pkg::CMD_BSPLINE:
            begin
                w_calc[0] = ssse;
                w_calc[1] = (ssse <<< 2) + ttte + (tsse <<< 3) + (tsse <<< 2)
                          + (ttse <<< 2) + (ttse <<< 1);
                w_calc[2] = (ttte <<< 2) + ssse + (ttse <<< 3) + (ttse <<< 2)
                          + (tsse <<< 2) + (tsse <<< 1);
                w_calc[3] = ttte;
            end
            ccci_pkg::CMD_CATMULL:
            begin
                w_calc[0] = -tsse;
                w_calc[1] = ccci_pkg::TWO_Q36 + (ttte <<< 1) + ttte
                          - (tte <<< 14) - (tte <<< 12);
                w_calc[2] = ccci_pkg::TWO_Q36 + (ssse <<< 1) + ssse
                          - (sse <<< 14) - (sse <<< 12);
                w_calc[3] = -ttse;
            end
            default:
            begin
                w_calc[0] = '0;
                w_calc[1] = '0;
                w_calc[2] = '0;
                w_calc[3] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg  <= t;
            s1_reg  <= s;
            t2_reg  <= t1_reg;
            s2_reg  <= s1_reg;
            tt2_reg <= tt_full[ccci_pkg::SQ_W-1:0];
            ss2_reg <= ss_full[ccci_pkg::SQ_W-1:0];
            t3_reg  <= t2_reg;
            s3_reg  <= s2_reg;
            tt3_reg <= tt2_reg;
            ss3_reg <= ss2_reg;
            ttt_reg <= ttt_full[ccci_pkg::CUBE_W-1:0];
            sss_reg <= sss_full[ccci_pkg::CUBE_W-1:0];
            tts_reg <= tts_full[ccci_pkg::CUBE_W-1:0];
            tss_reg <= tss_full[ccci_pkg::CUBE_W-1:0];
            for (int k = 0; k < ccci_pkg::NUM_TAPS; k++)
            begin
                wgt_reg[k] <= w_calc[k][ccci_pkg::WGT_W-1:0];
            end
        end
    end

    assign wgt = wgt_reg;

endmodule

// ----- rtl/ccci_lane.sv -----
`timescale 1ns / 1ps
// ccci_lane: one color channel; multiplies four taps by their weights, sums,
// rounds, divides by three for the B-spline and saturates. Depends on ccci_pkg.
module ccci_lane (
    input  logic                clk,
    input  logic                adv,
    input  ccci_pkg::cmd_t      mode,
    input  ccci_pkg::wgt_vec_t  wgt,
    input  ccci_pkg::tap_chan_t col,
    output ccci_pkg::chan_t     value
);

    logic signed [ccci_pkg::PROD_W-1:0]  prod_next [ccci_pkg::NUM_TAPS];
    logic signed [ccci_pkg::PROD_W-1:0]  prod_reg  [ccci_pkg::NUM_TAPS];
    ccci_pkg::cmd_t                      mode5_reg, mode6_reg;
    logic                                bspl7_reg, bspl8_reg;
    logic signed [ccci_pkg::ACC_W-1:0]   sum01_reg, sum23_reg, bias, acc_next, acc_sh;
    logic signed [ccci_pkg::Y_W-1:0]     y7_reg, y8_reg, q8, pick;
    logic [ccci_pkg::Y_W-1:0]            y_off;
    logic [ccci_pkg::DIV3_PROD_W-1:0]    div_next, div8_reg;
    logic [ccci_pkg::Q_W-1:0]            q_raw;

    function automatic ccci_pkg::chan_t sat16(input logic signed [ccci_pkg::Y_W-1:0] v);
        ccci_pkg::chan_t r;
        if (v > $signed(ccci_pkg::Y_W'(32767)))
        begin
            r = 16'sh7FFF;
        end
        else if (v < -$signed(ccci_pkg::Y_W'(32768)))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[ccci_pkg::CHAN_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        for (int k = 0; k < ccci_pkg::NUM_TAPS; k++)
        begin
            prod_next[k] = $signed(wgt[k]) * $signed(col[k]);
        end

        // Round to nearest, ties upward: add half the divisor, then floor-shift.
        bias     = (mode6_reg == ccci_pkg::CMD_BSPLINE) ? ccci_pkg::BIAS_BSPL
                                                         : ccci_pkg::BIAS_HALF;
        acc_next = sum01_reg + sum23_reg + bias;
        acc_sh   = acc_next >>> ccci_pkg::RND_SHIFT;

        // Floor division by three: offset to a positive value, multiply by the
        // reciprocal, then remove the offset again.
        y_off    = $unsigned(y7_reg) + ccci_pkg::Y_OFF;
        div_next = y_off[ccci_pkg::DIV3_IN_W-1:0] * ccci_pkg::DIV3_MUL;

        q_raw = div8_reg[ccci_pkg::DIV3_SHIFT +: ccci_pkg::Q_W];
        q8    = $signed({{(ccci_pkg::Y_W-ccci_pkg::Q_W){1'b0}}, q_raw}) - ccci_pkg::Q_OFF;
        pick  = bspl8_reg ? q8 : y8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ccci_pkg::NUM_TAPS; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            mode5_reg <= mode;
            sum01_reg <= ccci_pkg::ACC_W'(prod_reg[0]) + ccci_pkg::ACC_W'(prod_reg[1]);
            sum23_reg <= ccci_pkg::ACC_W'(prod_reg[2]) + ccci_pkg::ACC_W'(prod_reg[3]);
            mode6_reg <= mode5_reg;
            y7_reg    <= acc_sh[ccci_pkg::Y_W-1:0];
            bspl7_reg <= (mode6_reg == ccci_pkg::CMD_BSPLINE);
            y8_reg    <= y7_reg;
            div8_reg  <= div_next;
            bspl8_reg <= bspl7_reg;
        end
    end

    assign value = sat16(pick);

endmodule

// ----- rtl/ccci_merge.sv -----
`timescale 1ns / 1ps
// ccci_merge: joins the three channel lanes and the range flag into one result and
// holds it in an output register backed by a skid register. Depends on ccci_pkg.
module ccci_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccci_pkg::stage_ctl_t ctl,
    input  ccci_pkg::pix_t       chan,
    input  logic                 result_stall,
    output logic                 result_valid,
    output ccci_pkg::result_t    result,
    output logic                 pipe_adv
);

    logic              out_valid_reg, skid_valid_reg;
    ccci_pkg::result_t out_reg, skid_reg, arrive_data;
    logic              arrive, out_fire;

    // The pipeline only moves while the skid register is free.
    assign pipe_adv = !skid_valid_reg;
    assign arrive   = pipe_adv && ctl.valid;
    assign out_fire = out_valid_reg && !result_stall;

    always_comb
    begin
        arrive_data.range_error = ctl.err;
        arrive_data.out_red     = ctl.err ? '0 : chan[0];
        arrive_data.out_green   = ctl.err ? '0 : chan[1];
        arrive_data.out_blue    = ctl.err ? '0 : chan[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= arrive;
            end
            else
            begin
                if (arrive)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (arrive)
            begin
                out_reg <= arrive_data;
            end
        end
        else
        begin
            if (arrive)
            begin
                skid_reg <= arrive_data;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/cubic_curve_color_interpolator.sv -----
`timescale 1ns / 1ps
// Throughput: one request per cycle while request_stall is low; the 8-stage
// pipeline and the four table banks, each read once per cycle, set that rate.
// Write requests produce no result.
// Reset (rst_n, asynchronous) empties the pipeline and the output registers; the
// color table is not cleared and must be written before it is read.
module cubic_curve_color_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_stall,
    input  ccci_pkg::request_t request,
    output logic               result_valid,
    input  logic               result_stall,
    output ccci_pkg::result_t  result
);

    logic                             adv, accept, wr_fire;
    logic [ccci_pkg::IDX_EXT_W-1:0]   index_ext, last_entry;
    logic [ccci_pkg::U_W-1:0]         t0, s0;
    ccci_pkg::stage_ctl_t             ctl_next;
    ccci_pkg::stage_ctl_t             ctl_reg [1:ccci_pkg::NUM_STAGES];
    ccci_pkg::pix_t                   wr_pix;
    ccci_pkg::pix_t                   bank_rd [ccci_pkg::NUM_TAPS];
    logic [ccci_pkg::TAP_W-1:0]       rot1_reg;
    ccci_pkg::tap_pix_t               col2_next, col2_reg, col3_reg, col4_reg;
    ccci_pkg::wgt_vec_t               wgt4;
    ccci_pkg::tap_chan_t              lane_col [ccci_pkg::NUM_CH];
    ccci_pkg::pix_t                   lane_val;

    assign request_stall = !adv;
    assign accept        = request_valid && adv;
    assign index_ext     = {2'b00, request.index};
    assign wr_fire       = accept && (request.cmd == ccci_pkg::CMD_WRITE)
                           && (index_ext < ccci_pkg::DEPTH_EXT);

    always_comb
    begin
        last_entry = index_ext + ((request.cmd == ccci_pkg::CMD_LINEAR) ?
                                  ccci_pkg::LAST_LIN : ccci_pkg::LAST_CUBIC);
        ctl_next.valid = accept && (request.cmd != ccci_pkg::CMD_WRITE);
        ctl_next.err   = (last_entry >= ccci_pkg::DEPTH_EXT);
        ctl_next.cmd   = request.cmd;

        t0 = (request.param_u > ccci_pkg::ONE_Q12) ? ccci_pkg::ONE_Q12 : request.param_u;
        s0 = ccci_pkg::ONE_Q12 - t0;

        wr_pix[0] = request.write_red;
        wr_pix[1] = request.write_green;
        wr_pix[2] = request.write_blue;
    end

    // The table is split over four banks by the low index bits, so the four
    // consecutive entries of a segment always sit in different banks.
    for (genvar b = 0; b < ccci_pkg::NUM_TAPS; b++)
    begin : g_bank
        logic [ccci_pkg::TAP_W-1:0] off;
        logic [ccci_pkg::IDX_W:0]   entry;

        assign off   = ccci_pkg::TAP_W'(b) - request.index[ccci_pkg::TAP_W-1:0];
        assign entry = {1'b0, request.index}
                       + {{(ccci_pkg::IDX_W+1-ccci_pkg::TAP_W){1'b0}}, off};

        ccci_ram #(
            .WIDTH($bits(ccci_pkg::pix_t)),
            .DEPTH(ccci_pkg::BANK_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_fire && (request.index[ccci_pkg::TAP_W-1:0] == ccci_pkg::TAP_W'(b))),
            .wr_addr (request.index[ccci_pkg::TAP_W +: ccci_pkg::BANK_AW]),
            .wr_data (wr_pix),
            .rd_en   (adv),
            .rd_addr (entry[ccci_pkg::TAP_W +: ccci_pkg::BANK_AW]),
            .rd_data (bank_rd[b])
        );
    end

    // Rotate the bank outputs into tap order. Linear blends use only the middle
    // two taps, so the outer ones are forced to zero.
    always_comb
    begin
        for (int j = 0; j < ccci_pkg::NUM_TAPS; j++)
        begin
            if ((ctl_reg[1].cmd == ccci_pkg::CMD_LINEAR)
                && ((j == 0) || (j == ccci_pkg::NUM_TAPS - 1)))
            begin
                col2_next[j] = '0;
            end
            else
            begin
                col2_next[j] = bank_rd[rot1_reg + ccci_pkg::TAP_W'(j)];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= ccci_pkg::NUM_STAGES; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[1] <= ctl_next;
            for (int i = 2; i <= ccci_pkg::NUM_STAGES; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot1_reg <= request.index[ccci_pkg::TAP_W-1:0];
            col2_reg <= col2_next;
            col3_reg <= col2_reg;
            col4_reg <= col3_reg;
        end
    end

    ccci_weights u_weights (
        .clk  (clk),
        .adv  (adv),
        .t    (t0),
        .s    (s0),
        .mode (ctl_reg[3].cmd),
        .wgt  (wgt4)
    );

    always_comb
    begin
        for (int ch = 0; ch < ccci_pkg::NUM_CH; ch++)
        begin
            for (int k = 0; k < ccci_pkg::NUM_TAPS; k++)
            begin
                lane_col[ch][k] = col4_reg[k][ch];
            end
        end
    end

    for (genvar ch = 0; ch < ccci_pkg::NUM_CH; ch++)
    begin : g_lane
        ccci_lane u_lane (
            .clk   (clk),
            .adv   (adv),
            .mode  (ctl_reg[4].cmd),
            .wgt   (wgt4),
            .col   (lane_col[ch]),
            .value (lane_val[ch])
        );
    end

    ccci_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_reg[ccci_pkg::NUM_STAGES]),
        .chan         (lane_val),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .pipe_adv     (adv)
    );

endmodule

// ----- rtl/ccci_checker.sv -----
`timescale 1ns / 1ps
// ccci_checker: port-level assertions for the cubic curve color interpolator.
// Depends on ccci_pkg; attached to the top level by the bind at the end of this file.
module ccci_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               request_stall,
    input logic               result_valid,
    input logic               result_stall,
    input ccci_pkg::result_t  result
);

    // A segment that runs past the table always reports black.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.range_error) |->
            ((result.out_red == '0) && (result.out_green == '0) && (result.out_blue == '0)))
        else $error("range error result with nonzero color");

    // A result that is held back stays on the port unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed or dropped");

    // The request side only backs up after the result side has refused a result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(request_stall) |-> $past(result_valid && result_stall))
        else $error("request stall without a stalled result");

    // While requests are held off, a finished result is waiting on the port.
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        request_stall |-> result_valid)
        else $error("request stall with no pending result");

endmodule

bind cubic_curve_color_interpolator ccci_checker u_checker (.*);
